### rtl/bdd_pkg.sv
// Shared types and constants for the bounded deque with dump.
// Used by the controller, the datapath, the top level and the checker.
package bdd_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int REQ_W     = 2;
    localparam int KIND_W    = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_BACK  = 2'd0,
        REQ_FRONT = 2'd1,
        REQ_DUMP  = 2'd2
    } req_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACCEPTED = 3'd0,
        KIND_FORWARD  = 3'd1,
        KIND_REVERSE  = 3'd2,
        KIND_EMPTY    = 3'd3,
        KIND_DROPPED  = 3'd4
    } kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  latch;        // capture the incoming item
        logic  emit_status;  // load a status result into the output register
        kind_t status_kind;
        logic  push_wr;      // store the latched value and update pointers
        logic  dump_start;   // clear the dump sequencer
        logic  dump_run;     // let the dump sequencer issue reads
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             full;
        logic             empty;
        logic             out_free;
        logic             dump_done;
    } status_t;

endpackage

### rtl/bounded_deque_with_dump_top.sv
// Channel   Direction  Signals                      Contents
// s_*       in         tvalid tready tdata tuser    one request: value, req_type
// m_*       out        tvalid tready tdata tuser    one result: value_res, kind, last
//                      tlast
//
// A push is accepted, then executed into the output register.
// A dump is accepted, clears the sequencer and issues its first read, then loads one
// result per cycle while the output register is free (2 * occupancy results), then ends.
// The pace comes from the single read port of the entry memory and its registered data.
// Reset clears the pointers, the occupancy, the sequencer and the output valid;
// the entry memory is not cleared. A stalled result waits in the output register
// while the next item is accepted; that item then waits for the register to free.
// Top level of the bounded deque with dump; depends on bdd_pkg, bdd_ctrl, bdd_dp.
module bounded_deque_with_dump_top #(
    parameter int DEPTH = bdd_pkg::DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic signed [31:0] s_tdata,   // [31:0] value
    input  logic [1:0]  s_tuser,          // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic signed [31:0] m_tdata,   // [31:0] value_res
    output logic [2:0]  m_tuser,          // [2:0] kind
    output logic        m_tlast           // last
);
    import bdd_pkg::*;

    cmd_t    cmd;
    status_t status;

    bdd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bdd_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_req    (s_tuser),
        .in_value  (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (m_tuser),
        .out_value (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

### rtl/bdd_ctrl.sv
// Controller state machine for the bounded deque with dump.
// Depends on bdd_pkg; drives the datapath through cmd_t and watches status_t.
module bdd_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  bdd_pkg::status_t status,
    output bdd_pkg::cmd_t   cmd
);
    import bdd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DUMP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next       = state_reg;
        in_ready         = 1'b0;
        cmd              = '0;
        cmd.status_kind  = KIND_ACCEPTED;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (status.req)
                    REQ_BACK, REQ_FRONT:
                    begin
                        if (status.out_free)
                        begin
                            cmd.emit_status = 1'b1;
                            cmd.status_kind = status.full ? KIND_DROPPED : KIND_ACCEPTED;
                            cmd.push_wr     = !status.full;
                            state_next      = ST_IDLE;
                        end
                    end
                    REQ_DUMP:
                    begin
                        if (status.empty)
                        begin
                            if (status.out_free)
                            begin
                                cmd.emit_status = 1'b1;
                                cmd.status_kind = KIND_EMPTY;
                                state_next      = ST_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.dump_start = 1'b1;
                            state_next     = ST_DUMP;
                        end
                    end
                    default:
                    begin
                        // Unused request code: the item is dropped silently.
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_DUMP:
            begin
                cmd.dump_run = 1'b1;
                if (status.dump_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/bdd_dp.sv
// Datapath of the bounded deque with dump: entry memory, ring pointers,
// dump sequencer with read-ahead register, and the output register.
// Depends on bdd_pkg; controlled by bdd_ctrl through cmd_t.
module bdd_dp #(
    parameter int DEPTH = bdd_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [bdd_pkg::REQ_W-1:0]     in_req,
    input  logic signed [bdd_pkg::DATA_W-1:0] in_value,
    input  bdd_pkg::cmd_t                 cmd,
    output bdd_pkg::status_t              status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bdd_pkg::KIND_W-1:0]    out_kind,
    output logic signed [bdd_pkg::DATA_W-1:0] out_value,
    output logic                          out_last
);
    import bdd_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int OW = $clog2(DEPTH + 1);
    localparam int CW = OW + 1;
    localparam logic [IW:0]   DEPTH_S   = (IW + 1)'(DEPTH);
    localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);
    localparam logic [OW-1:0] DEPTH_O   = OW'(DEPTH);

    logic [DATA_W-1:0] mem [DEPTH];

    logic [REQ_W-1:0]  req_reg;
    logic [DATA_W-1:0] val_reg;
    logic [IW-1:0]     front_reg, front_next;
    logic [OW-1:0]     occ_reg, occ_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              rdv_reg, rdv_next;
    logic [DATA_W-1:0] rd_data_reg;
    logic [KIND_W-1:0] rd_kind_reg;
    logic              rd_last_reg;
    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] out_kind_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic              out_last_reg;

    logic              full, empty, out_free;
    logic [CW-1:0]     total, off_c;
    logic              fwd, issue, load;
    logic [IW:0]       back_sum, back_wrap, rd_sum, rd_wrap;
    logic [IW-1:0]     back_slot, front_dec, rd_addr, wr_addr;

    assign full     = (occ_reg == DEPTH_O);
    assign empty    = (occ_reg == '0);
    assign out_free = !out_valid_reg || out_ready;

    // Back slot sits occupancy entries past the front, wrapped around the ring.
    assign back_sum  = {1'b0, front_reg} + (IW + 1)'(occ_reg);
    assign back_wrap = (back_sum >= DEPTH_S) ? back_sum - DEPTH_S : back_sum;
    assign back_slot = back_wrap[IW-1:0];
    assign front_dec = (front_reg == '0) ? LAST_SLOT : front_reg - 1'b1;
    assign wr_addr   = (req_reg == REQ_FRONT) ? front_dec : back_slot;

    // The dump walks offsets 0..n-1 and then n-1..0.
    assign total   = {occ_reg, 1'b0};
    assign fwd     = (cnt_reg < {1'b0, occ_reg});
    assign off_c   = fwd ? cnt_reg : total - CW'(1) - cnt_reg;
    assign rd_sum  = {1'b0, front_reg} + {1'b0, off_c[IW-1:0]};
    assign rd_wrap = (rd_sum >= DEPTH_S) ? rd_sum - DEPTH_S : rd_sum;
    assign rd_addr = rd_wrap[IW-1:0];

    // The read register holds one entry ahead of the output register.
    assign load  = rdv_reg && out_free;
    assign issue = cmd.dump_run && (cnt_reg != total) && (!rdv_reg || load);

    always_comb
    begin
        front_next = front_reg;
        occ_next   = occ_reg;
        if (cmd.push_wr)
        begin
            occ_next = occ_reg + 1'b1;
            if (req_reg == REQ_FRONT)
            begin
                front_next = front_dec;
            end
        end

        cnt_next = cnt_reg;
        if (cmd.dump_start)
        begin
            cnt_next = '0;
        end
        else if (issue)
        begin
            cnt_next = cnt_reg + 1'b1;
        end

        rdv_next = rdv_reg;
        if (cmd.dump_start)
        begin
            rdv_next = 1'b0;
        end
        else if (issue)
        begin
            rdv_next = 1'b1;
        end
        else if (load)
        begin
            rdv_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (cmd.emit_status || load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            occ_reg       <= '0;
            cnt_reg       <= '0;
            rdv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            occ_reg       <= occ_next;
            cnt_reg       <= cnt_next;
            rdv_reg       <= rdv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg <= in_req;
            val_reg <= in_value;
        end
        if (cmd.push_wr)
        begin
            mem[wr_addr] <= val_reg;
        end
        if (issue)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_kind_reg <= fwd ? KIND_FORWARD : KIND_REVERSE;
            rd_last_reg <= (cnt_reg == total - CW'(1));
        end
        if (cmd.emit_status)
        begin
            out_kind_reg  <= cmd.status_kind;
            out_value_reg <= '0;
            out_last_reg  <= 1'b1;
        end
        else if (load)
        begin
            out_kind_reg  <= rd_kind_reg;
            out_value_reg <= rd_data_reg;
            out_last_reg  <= rd_last_reg;
        end
    end

    assign status.req       = req_reg;
    assign status.full      = full;
    assign status.empty     = empty;
    assign status.out_free  = out_free;
    assign status.dump_done = (cnt_reg == total) && !rdv_reg;

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

endmodule

### rtl/bdd_chk.sv
// Port-level checker for the bounded deque with dump, bound to the top level.
// Depends on bdd_pkg for the result kind codes.
module bdd_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);
    import bdd_pkg::*;

    // A result held under backpressure keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // Status results are single, zero valued and marked last.
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_ACCEPTED || m_tuser == KIND_DROPPED
            || m_tuser == KIND_EMPTY) |-> m_tlast && m_tdata == 32'd0)
        else $error("status result malformed");

    // The forward half of a dump is never the final result.
    a_fwd_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_FORWARD |-> !m_tlast)
        else $error("forward element marked last");

    // Only one item is worked on at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted on consecutive cycles");

    // A reverse element is never followed directly by a forward one.
    a_rev_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tuser == KIND_REVERSE && !m_tlast
            ##1 m_tvalid |-> m_tuser == KIND_REVERSE)
        else $error("dump order broken");

endmodule

bind bounded_deque_with_dump_top bdd_chk u_bdd_chk (.*);
